>>> sv/mtdc_pkg.sv
package mtdc_pkg;

  // Field widths of the item formats
  localparam int unsigned FW = 3;

  // Input modes
  localparam logic [FW-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [FW-1:0] MODE_LOCK    = 3'd1;
  localparam logic [FW-1:0] MODE_UNLOCK  = 3'd2;
  localparam logic [FW-1:0] MODE_DESTROY = 3'd3;
  localparam logic [FW-1:0] MODE_SCAN    = 3'd4;

  // Result status codes
  localparam logic [FW-1:0] ST_OK          = 3'd0;
  localparam logic [FW-1:0] ST_FULL        = 3'd1;
  localparam logic [FW-1:0] ST_NOT_OWNER   = 3'd2;
  localparam logic [FW-1:0] ST_BUSY        = 3'd3;
  localparam logic [FW-1:0] ST_WAITING     = 3'd4;
  localparam logic [FW-1:0] ST_PAIR        = 3'd5;
  localparam logic [FW-1:0] ST_NO_DEADLOCK = 3'd6;

  // Number of threads (one wait mark each)
  localparam int unsigned THREADS = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_SCAN_I,
    S_SCAN_J,
    S_SCAN_END
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture the accepted item
    logic exec_op;    // run allocate/lock/unlock/destroy, write result
    logic scan_init;  // restart row counter, drop pending pair
    logic latch_a;    // capture row i entry, start column at i+1
    logic inc_i;      // next row
    logic inc_j;      // next column
    logic push_pair;  // record found pair, older pending one goes out
    logic emit_end;   // final scan item
    logic rd_i;       // table read address is row counter
    logic rd_j;       // table read address is column counter
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FW-1:0] mode;
    logic          i_done;
    logic          j_done;
    logic          rd_held;
    logic          match;
    logic          pend_valid;
    logic          out_free;
  } stat_t;

endpackage

>>> sv/mtdc_dp.sv
module mtdc_dp #(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mtdc_pkg::cmd_t        cmd,
  output mtdc_pkg::stat_t       stat,
  input  logic [15:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,
  output logic                  m_tlast
);

  // Only indices 0..7 are addressable, so no entries past that are stored
  localparam int NUM = (SLOTS < 8) ? SLOTS : 8;
  localparam int IW  = $clog2(NUM);
  localparam int AW  = $clog2(SLOTS);
  localparam int CW  = AW + 1;
  localparam int FW  = mtdc_pkg::FW;

  // Mutex table
  logic                        held [NUM];
  logic [FW-1:0]               holder [NUM];
  logic [mtdc_pkg::THREADS-1:0] wait_marks [NUM];
  logic [AW-1:0]               allocated;

  // Captured item
  logic [FW-1:0] mode, idx, tid;

  // Scan counters and row-i snapshot
  logic [CW-1:0]               i_cnt, j_cnt;
  logic [FW-1:0]               a_holder;
  logic [mtdc_pkg::THREADS-1:0] a_wait;

  // Pending pair (held back until we know whether it is the last one)
  logic          pend_valid;
  logic [FW-1:0] pend_m1, pend_m2, pend_h1, pend_h2;

  // Output register
  logic          out_valid;
  logic [FW-1:0] out_st, out_m1, out_m2, out_h1, out_h2;
  logic          out_last;

  logic                        out_free;
  logic [CW-1:0]               lim;
  logic [IW-1:0]               rd_addr;
  logic                        rd_held;
  logic [FW-1:0]               rd_holder;
  logic [mtdc_pkg::THREADS-1:0] rd_wait;
  logic                        match;
  logic                        idx_ok;
  logic                        alloc_full;
  logic                        alloc_in;
  logic [IW-1:0]               alloc_addr;
  logic [FW-1:0]               op_st;
  logic [FW-1:0]               op_m1;

  assign out_free = !out_valid || m_tready;

  // Scan covers allocated indices that can hold a mutex
  assign lim = (CW'(allocated) < CW'(NUM)) ? CW'(allocated) : CW'(NUM);

  // Single table read port
  always_comb begin
    if (cmd.rd_i) begin
      rd_addr = i_cnt[IW-1:0];
    end else if (cmd.rd_j) begin
      rd_addr = j_cnt[IW-1:0];
    end else begin
      rd_addr = idx[IW-1:0];
    end
  end
  assign rd_held   = held[rd_addr];
  assign rd_holder = holder[rd_addr];
  assign rd_wait   = wait_marks[rd_addr];

  // Row i holder waits on entry j and entry j holder waits on row i
  assign match = rd_held && (rd_holder != a_holder) &&
                 a_wait[rd_holder] && rd_wait[a_holder];

  assign idx_ok     = int'(idx) < SLOTS;
  assign alloc_full = allocated >= AW'(SLOTS - 1);
  assign alloc_in   = CW'(allocated) < CW'(NUM);
  assign alloc_addr = allocated[IW-1:0];

  // Result of a single operation
  always_comb begin
    op_st = mtdc_pkg::ST_OK;
    op_m1 = '0;
    unique case (mode)
      mtdc_pkg::MODE_ALLOC: begin
        if (alloc_full) begin
          op_st = mtdc_pkg::ST_FULL;
        end else begin
          op_m1 = FW'(allocated);
        end
      end
      mtdc_pkg::MODE_LOCK: begin
        if (!idx_ok) begin
          op_st = mtdc_pkg::ST_NOT_OWNER;
        end else if (rd_held && rd_holder != tid) begin
          op_st = mtdc_pkg::ST_WAITING;
        end
      end
      mtdc_pkg::MODE_UNLOCK: begin
        if (!idx_ok || !rd_held || rd_holder != tid) begin
          op_st = mtdc_pkg::ST_NOT_OWNER;
        end
      end
      mtdc_pkg::MODE_DESTROY: begin
        if (!idx_ok) begin
          op_st = mtdc_pkg::ST_NOT_OWNER;
        end else if (rd_held) begin
          op_st = mtdc_pkg::ST_BUSY;
        end
      end
      default: begin
        op_st = mtdc_pkg::ST_OK;
      end
    endcase
  end

  // Table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM; k++) begin
        held[k]       <= 1'b0;
        holder[k]     <= '0;
        wait_marks[k] <= '0;
      end
      allocated <= '0;
    end else if (cmd.exec_op) begin
      unique case (mode)
        mtdc_pkg::MODE_ALLOC: begin
          if (!alloc_full) begin
            if (alloc_in) begin
              held[alloc_addr]       <= 1'b0;
              holder[alloc_addr]     <= '0;
              wait_marks[alloc_addr] <= '0;
            end
            allocated <= allocated + AW'(1);
          end
        end
        mtdc_pkg::MODE_LOCK: begin
          if (idx_ok) begin
            if (!rd_held) begin
              held[rd_addr]   <= 1'b1;
              holder[rd_addr] <= tid;
            end else if (rd_holder != tid) begin
              wait_marks[rd_addr][tid] <= 1'b1;
            end
          end
        end
        mtdc_pkg::MODE_UNLOCK: begin
          if (idx_ok && rd_held && rd_holder == tid) begin
            held[rd_addr]       <= 1'b0;
            holder[rd_addr]     <= '0;
            wait_marks[rd_addr] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode <= s_tdata[2:0];
      idx  <= s_tdata[5:3];
      tid  <= s_tdata[8:6];
    end
  end

  // Scan counters and row snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt <= '0;
      j_cnt <= '0;
    end else begin
      if (cmd.scan_init) begin
        i_cnt <= '0;
      end else if (cmd.inc_i) begin
        i_cnt <= i_cnt + CW'(1);
      end
      if (cmd.latch_a) begin
        j_cnt <= i_cnt + CW'(1);
      end else if (cmd.inc_j || cmd.push_pair) begin
        j_cnt <= j_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      a_holder <= rd_holder;
      a_wait   <= rd_wait;
    end
  end

  // Pending pair
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_init || cmd.emit_end) begin
      pend_valid <= 1'b0;
    end else if (cmd.push_pair) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pair) begin
      pend_m1 <= FW'(i_cnt);
      pend_m2 <= FW'(j_cnt);
      pend_h1 <= a_holder;
      pend_h2 <= rd_holder;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_op || cmd.emit_end || (cmd.push_pair && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      out_st   <= op_st;
      out_m1   <= op_m1;
      out_m2   <= '0;
      out_h1   <= '0;
      out_h2   <= '0;
      out_last <= 1'b1;
    end else if (cmd.emit_end || (cmd.push_pair && pend_valid)) begin
      if (pend_valid) begin
        out_st <= mtdc_pkg::ST_PAIR;
        out_m1 <= pend_m1;
        out_m2 <= pend_m2;
        out_h1 <= pend_h1;
        out_h2 <= pend_h2;
      end else begin
        out_st <= mtdc_pkg::ST_NO_DEADLOCK;
        out_m1 <= '0;
        out_m2 <= '0;
        out_h1 <= '0;
        out_h2 <= '0;
      end
      out_last <= cmd.emit_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_h2, out_h1, out_m2, out_m1, out_st};
  assign m_tlast  = out_last;

  // Status to the controller
  assign stat.mode       = mode;
  assign stat.i_done     = i_cnt >= lim;
  assign stat.j_done     = j_cnt >= lim;
  assign stat.rd_held    = rd_held;
  assign stat.match      = match;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

endmodule

>>> sv/mtdc_ctrl.sv
module mtdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mtdc_pkg::stat_t  stat,
  output mtdc_pkg::cmd_t   cmd
);

  mtdc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      mtdc_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = mtdc_pkg::S_OP;
        end
      end
      mtdc_pkg::S_OP: begin
        if (stat.mode == mtdc_pkg::MODE_SCAN) begin
          cmd.scan_init = 1'b1;
          state_next    = mtdc_pkg::S_SCAN_I;
        end else if (stat.mode == mtdc_pkg::MODE_ALLOC || stat.mode == mtdc_pkg::MODE_LOCK ||
                     stat.mode == mtdc_pkg::MODE_UNLOCK ||
                     stat.mode == mtdc_pkg::MODE_DESTROY) begin
          if (stat.out_free) begin
            cmd.exec_op = 1'b1;
            state_next  = mtdc_pkg::S_IDLE;
          end
        end else begin
          // unused mode: no result
          state_next = mtdc_pkg::S_IDLE;
        end
      end
      mtdc_pkg::S_SCAN_I: begin
        cmd.rd_i = 1'b1;
        if (stat.i_done) begin
          state_next = mtdc_pkg::S_SCAN_END;
        end else if (stat.rd_held) begin
          cmd.latch_a = 1'b1;
          state_next  = mtdc_pkg::S_SCAN_J;
        end else begin
          cmd.inc_i = 1'b1;
        end
      end
      mtdc_pkg::S_SCAN_J: begin
        cmd.rd_j = 1'b1;
        if (stat.j_done) begin
          cmd.inc_i  = 1'b1;
          state_next = mtdc_pkg::S_SCAN_I;
        end else if (stat.match) begin
          // older pending pair must find room in the output register
          if (!stat.pend_valid || stat.out_free) begin
            cmd.push_pair = 1'b1;
          end
        end else begin
          cmd.inc_j = 1'b1;
        end
      end
      mtdc_pkg::S_SCAN_END: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = mtdc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mtdc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/mutex_table_deadlock_check.sv
// Table of SLOTS hardware mutexes (indices 0..7 addressable) with a
// deadlock scan. Allocate, lock, unlock and destroy each give one result
// item; an item is taken in S_IDLE and its result is written to the
// output register from S_OP once that register is free, so no new item
// is taken before the result of the last one is written. A finished
// result may wait in the output register while the next item is
// accepted. The scan walks the table through a single read port. After
// the item is taken it starts the scan, visits each allocated row,
// walks the later columns of each held row and returns, and then
// finishes with the final item. With eight slots at most seven rows are
// in use. A found pair or the final item may wait for the output
// register, which stalls the scan. The scan gives one item per
// deadlocked pair (lower index first) and marks the last with tlast;
// with no pair it gives a single no-deadlock item. A found pair is held
// back until the next one or the scan end, so the last can be flagged.
module mutex_table_deadlock_check #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[2:0], mutex_index[5:3], thread_id[8:6], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[2:0], first_mutex[5:3], second_mutex[8:6],
                                 // first_holder[11:9], second_holder[14:12], zero
  output logic        m_tlast
);

  mtdc_pkg::cmd_t  cmd;
  mtdc_pkg::stat_t stat;

  mtdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtdc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/mtdc_checker.sv
module mtdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Only deadlock pairs may be followed by more results
  a_nonlast_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[2:0] == mtdc_pkg::ST_PAIR)
    else $error("non-final result is not a deadlock pair");

  // Pair ordering and distinct holders
  a_pair_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == mtdc_pkg::ST_PAIR |->
      m_tdata[5:3] < m_tdata[8:6] && m_tdata[11:9] != m_tdata[14:12])
    else $error("malformed deadlock pair");

  // No-deadlock item is final with zero fields
  a_no_dl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == mtdc_pkg::ST_NO_DEADLOCK |->
      m_tlast && m_tdata[15:3] == 13'd0)
    else $error("malformed no-deadlock result");

  // Sequential: items are never accepted back to back
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted back to back");

endmodule

bind mutex_table_deadlock_check mtdc_checker u_mtdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> test/tb_top.sv
module tb_top;

  // Modes the block ignores
  localparam logic [mtdc_pkg::FW-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [mtdc_pkg::FW-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [mtdc_pkg::FW-1:0] MODE_RSVD7 = 3'd7;

  localparam int NUM_MUTEX     = 8;
  localparam int MAX_PAIRS     = 28;
  localparam int RANDOM_ITEMS  = 380;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] first_mutex;
    logic [2:0] second_mutex;
    logic [2:0] first_holder;
    logic [2:0] second_holder;
    logic       last;
  } mutex_result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] idx;
    logic [2:0] tid;
    logic       typed;
    logic [2:0] exp_status;
    logic [2:0] exp_mutex;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // Shadow copy of the mutex table
  logic        mx_held   [NUM_MUTEX];
  logic [2:0]  mx_holder [NUM_MUTEX];
  logic [7:0]  mx_waits  [NUM_MUTEX];
  int unsigned mx_alloc_cnt;

  mutex_result_t expected_results[$];
  int            err_count = 0;
  int            cycle_count = 0;
  logic          quiet = 1'b0;
  int            ready_hold = 0;

  // Directed items: typed results where they are obvious, else predicted
  dir_row_t dir_rows [27] = '{
    '{mtdc_pkg::MODE_SCAN,    3'd0, 3'd0, 1'b1, mtdc_pkg::ST_NO_DEADLOCK, 3'd0},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_ALLOC,   3'd5, 3'd2, 1'b1, mtdc_pkg::ST_OK,          3'd1},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd2},
    '{mtdc_pkg::MODE_LOCK,    3'd0, 3'd7, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd0, 3'd7, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd1, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd0, 3'd0, 1'b1, mtdc_pkg::ST_WAITING,     3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd1, 3'd7, 1'b1, mtdc_pkg::ST_WAITING,     3'd0},
    '{mtdc_pkg::MODE_SCAN,    3'd0, 3'd0, 1'b0, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_UNLOCK,  3'd1, 3'd7, 1'b1, mtdc_pkg::ST_NOT_OWNER,   3'd0},
    '{mtdc_pkg::MODE_UNLOCK,  3'd2, 3'd3, 1'b1, mtdc_pkg::ST_NOT_OWNER,   3'd0},
    '{mtdc_pkg::MODE_DESTROY, 3'd0, 3'd5, 1'b1, mtdc_pkg::ST_BUSY,        3'd0},
    '{mtdc_pkg::MODE_DESTROY, 3'd2, 3'd2, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd3, 3'd1, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd3},
    '{mtdc_pkg::MODE_DESTROY, 3'd3, 3'd6, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{MODE_RSVD5,             3'd7, 3'd7, 1'b0, mtdc_pkg::ST_OK,          3'd0},
    '{MODE_RSVD6,             3'd2, 3'd5, 1'b0, mtdc_pkg::ST_OK,          3'd0},
    '{MODE_RSVD7,             3'd5, 3'd2, 1'b0, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_UNLOCK,  3'd0, 3'd7, 1'b1, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_SCAN,    3'd0, 3'd0, 1'b0, mtdc_pkg::ST_OK,          3'd0},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd4},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd5},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_OK,          3'd6},
    '{mtdc_pkg::MODE_ALLOC,   3'd0, 3'd0, 1'b1, mtdc_pkg::ST_FULL,        3'd0},
    '{mtdc_pkg::MODE_LOCK,    3'd7, 3'd7, 1'b0, mtdc_pkg::ST_OK,          3'd0}
  };

  mutex_table_deadlock_check #(
    .SLOTS(NUM_MUTEX)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Expected results of one accepted item; updates the shadow table
  task automatic predict_mutex_op(input logic [2:0] mode, input logic [2:0] idx,
                                  input logic [2:0] tid);
    mutex_result_t r;
    mutex_result_t pairs[$];
    int unsigned   lim;
    r = '0;
    r.last = 1'b1;
    case (mode)
      mtdc_pkg::MODE_ALLOC: begin
        if (mx_alloc_cnt >= NUM_MUTEX - 1) begin
          r.status = mtdc_pkg::ST_FULL;
        end else begin
          mx_held[mx_alloc_cnt]   = 1'b0;
          mx_holder[mx_alloc_cnt] = 3'd0;
          mx_waits[mx_alloc_cnt]  = 8'd0;
          r.status      = mtdc_pkg::ST_OK;
          r.first_mutex = 3'(mx_alloc_cnt);
          mx_alloc_cnt++;
        end
        expected_results.push_back(r);
      end
      mtdc_pkg::MODE_LOCK: begin
        if (!mx_held[idx]) begin
          mx_held[idx]   = 1'b1;
          mx_holder[idx] = tid;
          r.status       = mtdc_pkg::ST_OK;
        end else if (mx_holder[idx] == tid) begin
          r.status = mtdc_pkg::ST_OK;
        end else begin
          mx_waits[idx][tid] = 1'b1;
          r.status = mtdc_pkg::ST_WAITING;
        end
        expected_results.push_back(r);
      end
      mtdc_pkg::MODE_UNLOCK: begin
        if (mx_held[idx] && mx_holder[idx] == tid) begin
          mx_held[idx]   = 1'b0;
          mx_holder[idx] = 3'd0;
          mx_waits[idx]  = 8'd0;
          r.status       = mtdc_pkg::ST_OK;
        end else begin
          r.status = mtdc_pkg::ST_NOT_OWNER;
        end
        expected_results.push_back(r);
      end
      mtdc_pkg::MODE_DESTROY: begin
        r.status = mx_held[idx] ? mtdc_pkg::ST_BUSY : mtdc_pkg::ST_OK;
        expected_results.push_back(r);
      end
      mtdc_pkg::MODE_SCAN: begin
        lim = (mx_alloc_cnt < NUM_MUTEX) ? mx_alloc_cnt : NUM_MUTEX;
        for (int i = 0; i < lim; i++) begin
          if (!mx_held[i]) continue;
          for (int j = i + 1; j < lim; j++) begin
            if (!mx_held[j] || mx_holder[i] == mx_holder[j]) continue;
            if (mx_waits[i][mx_holder[j]] && mx_waits[j][mx_holder[i]] &&
                pairs.size() < MAX_PAIRS) begin
              r = '0;
              r.status        = mtdc_pkg::ST_PAIR;
              r.first_mutex   = 3'(i);
              r.second_mutex  = 3'(j);
              r.first_holder  = mx_holder[i];
              r.second_holder = mx_holder[j];
              pairs.push_back(r);
            end
          end
        end
        if (pairs.size() == 0) begin
          r = '0;
          r.status = mtdc_pkg::ST_NO_DEADLOCK;
          r.last   = 1'b1;
          expected_results.push_back(r);
        end else begin
          pairs[pairs.size() - 1].last = 1'b1;
          foreach (pairs[k]) expected_results.push_back(pairs[k]);
        end
      end
      default: ;  // unused modes: no result
    endcase
  endtask

  // Offer one item after a random gap, predict it once accepted
  task automatic send_item(input logic [2:0] mode, input logic [2:0] idx,
                           input logic [2:0] tid);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, tid, idx, mode};
    do @(posedge clk); while (!s_tready);
    predict_mutex_op(mode, idx, tid);
  endtask

  // Quiet stretches with no idling on either side; stop at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 128 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      ready_hold = pick_gap();
      if (ready_hold > 0) begin
        m_tready <= 1'b0;
        ready_hold = ready_hold - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mutex_result_t got;
    mutex_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[2:0], m_tdata[5:3], m_tdata[8:6], m_tdata[11:9],
              m_tdata[14:12], m_tlast};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d m=%0d/%0d h=%0d/%0d last=%0b", $time,
                 got.status, got.first_mutex, got.second_mutex, got.first_holder,
                 got.second_holder, got.last);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d m=%0d/%0d h=%0d/%0d last=%0b", $time,
                   want.status, want.first_mutex, want.second_mutex, want.first_holder,
                   want.second_holder, want.last);
          $display("%0t:          actual   st=%0d m=%0d/%0d h=%0d/%0d last=%0b", $time,
                   got.status, got.first_mutex, got.second_mutex, got.first_holder,
                   got.second_holder, got.last);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int            sent;
    int            r;
    int            i;
    int            j;
    int            a;
    int            b;
    int            held_idx[$];
    mutex_result_t typed_res;

    for (int k = 0; k < NUM_MUTEX; k++) begin
      mx_held[k]   = 1'b0;
      mx_holder[k] = 3'd0;
      mx_waits[k]  = 8'd0;
    end
    mx_alloc_cnt = 0;
    sent = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].mode, dir_rows[k].idx, dir_rows[k].tid);
      if (dir_rows[k].typed) begin
        typed_res = '0;
        typed_res.status      = dir_rows[k].exp_status;
        typed_res.first_mutex = dir_rows[k].exp_mutex;
        typed_res.last        = 1'b1;
        void'(expected_results.pop_back());
        expected_results.push_back(typed_res);
      end
    end

    // Random part: deadlock recipes mixed with single random items
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // two threads each take one mutex and then wait on the other's
        i = $urandom_range(0, NUM_MUTEX - 2);
        j = (i + $urandom_range(1, NUM_MUTEX - 2)) % (NUM_MUTEX - 1);
        a = $urandom_range(0, 7);
        b = (a + $urandom_range(1, 7)) % 8;
        send_item(mtdc_pkg::MODE_LOCK, 3'(i), 3'(a));
        send_item(mtdc_pkg::MODE_LOCK, 3'(j), 3'(b));
        send_item(mtdc_pkg::MODE_LOCK, 3'(i), 3'(b));
        send_item(mtdc_pkg::MODE_LOCK, 3'(j), 3'(a));
        send_item(mtdc_pkg::MODE_SCAN, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        sent += 5;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(mtdc_pkg::MODE_ALLOC, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)));
          sent++;
        end else if (r < 38) begin
          i = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
          send_item(mtdc_pkg::MODE_LOCK, 3'(i), 3'($urandom_range(0, 7)));
          sent++;
        end else if (r < 62) begin
          held_idx.delete();
          for (int k = 0; k < NUM_MUTEX; k++) if (mx_held[k]) held_idx.push_back(k);
          if (held_idx.size() > 0 && $urandom_range(0, 9) < 7) begin
            i = held_idx[$urandom_range(0, held_idx.size() - 1)];
            send_item(mtdc_pkg::MODE_UNLOCK, 3'(i), mx_holder[i]);
          end else begin
            send_item(mtdc_pkg::MODE_UNLOCK, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
          end
          sent++;
        end else if (r < 72) begin
          send_item(mtdc_pkg::MODE_DESTROY, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)));
          sent++;
        end else if (r < 92) begin
          send_item(mtdc_pkg::MODE_SCAN, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)));
          sent++;
        end else begin
          // ignored modes do not count
          send_item(3'($urandom_range(MODE_RSVD5, MODE_RSVD7)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)));
        end
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain, then allow for stray results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mtdc_pkg.sv
sv/mtdc_dp.sv
sv/mtdc_ctrl.sv
sv/mutex_table_deadlock_check.sv
sv/mtdc_checker.sv
test/tb_top.sv
